@@ sv/bas_pkg.sv @@
// Shared types, constants and helpers for the battery alert sequencer.
// No dependencies; every other file in sv/ imports this package.

package bas_pkg;

  localparam int unsigned MsW    = 12;
  localparam int unsigned LevelW = 7;
  localparam int unsigned CountW = 4;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [MsW-1:0] ElapsedMax = '1;

  localparam logic [MsW-1:0]    StartupDelayRst = MsW'(50 * 45);
  localparam logic [MsW-1:0]    BlinkPeriodRst  = MsW'(140);
  localparam logic [LevelW-1:0] LowLevelRst     = LevelW'(5);
  localparam logic [LevelW-1:0] CritLevelRst    = LevelW'(1);
  localparam logic [CountW-1:0] FlashTogglesRst = CountW'(6);
  localparam logic [CountW-1:0] AlertTogglesRst = CountW'(10);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STARTUP_DELAY = 3'd0,
    CFG_BLINK_PERIOD  = 3'd1,
    CFG_LOW_LEVEL     = 3'd2,
    CFG_CRIT_LEVEL    = 3'd3,
    CFG_FLASH_TOGGLES = 3'd4,
    CFG_ALERT_TOGGLES = 3'd5
  } cfg_idx_e;

  typedef enum logic [6:0] {
    PH_OFF       = 7'b0000001,
    PH_CHECK     = 7'b0000010,
    PH_STARTUP   = 7'b0000100,
    PH_FLASH     = 7'b0001000,
    PH_PON_ALERT = 7'b0010000,
    PH_RUNTIME   = 7'b0100000,
    PH_RT_ALERT  = 7'b1000000
  } phase_e;

  localparam logic [PhaseW-1:0] CodeOff      = 3'd0;
  localparam logic [PhaseW-1:0] CodeCheck    = 3'd1;
  localparam logic [PhaseW-1:0] CodeStartup  = 3'd2;
  localparam logic [PhaseW-1:0] CodeFlash    = 3'd3;
  localparam logic [PhaseW-1:0] CodePonAlert = 3'd4;
  localparam logic [PhaseW-1:0] CodeRuntime  = 3'd5;
  localparam logic [PhaseW-1:0] CodeRtAlert  = 3'd6;

  typedef struct packed {
    logic [MsW-1:0]    startup_delay_ms;
    logic [MsW-1:0]    blink_period_ms;
    logic [LevelW-1:0] low_level;
    logic [LevelW-1:0] critical_level;
    logic [CountW-1:0] flash_toggles;
    logic [CountW-1:0] alert_toggles;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [LevelW-1:0] charge_pct;
    logic              level_valid;
    logic              need_charge_stored;
  } item_t;

  typedef struct packed {
    phase_e            phase;
    logic [MsW-1:0]    elapsed_ms;
    logic [CountW-1:0] toggle_count;
    logic              need_charge;
  } seq_state_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              buzzer_on;
    logic              led_power_pulse;
    logic              store_request;
    logic              need_charge;
    logic              runtime_alert_pulse;
    logic              shutdown_pulse;
    logic              power_on_done;
  } result_t;

  function automatic logic [PhaseW-1:0] phase_code(input phase_e ph);
    logic [PhaseW-1:0] code;
    unique case (ph)
      PH_OFF:       code = CodeOff;
      PH_CHECK:     code = CodeCheck;
      PH_STARTUP:   code = CodeStartup;
      PH_FLASH:     code = CodeFlash;
      PH_PON_ALERT: code = CodePonAlert;
      PH_RUNTIME:   code = CodeRuntime;
      PH_RT_ALERT:  code = CodeRtAlert;
      default:      code = CodeOff;
    endcase
    return code;
  endfunction

endpackage

@@ sv/bas_cfg_regs.sv @@
// Configuration register file of the battery alert sequencer.
// Depends on bas_pkg for the register indexes, reset values and cfg_t.

module bas_cfg_regs import bas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [MsW-1:0]     wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_STARTUP_DELAY: cfg_d.startup_delay_ms = wr_data_i;
        CFG_BLINK_PERIOD:  cfg_d.blink_period_ms  = wr_data_i;
        CFG_LOW_LEVEL:     cfg_d.low_level        = wr_data_i[LevelW-1:0];
        CFG_CRIT_LEVEL:    cfg_d.critical_level   = wr_data_i[LevelW-1:0];
        CFG_FLASH_TOGGLES: cfg_d.flash_toggles    = wr_data_i[CountW-1:0];
        CFG_ALERT_TOGGLES: cfg_d.alert_toggles    = wr_data_i[CountW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_delay_ms <= StartupDelayRst;
      cfg_q.blink_period_ms  <= BlinkPeriodRst;
      cfg_q.low_level        <= LowLevelRst;
      cfg_q.critical_level   <= CritLevelRst;
      cfg_q.flash_toggles    <= FlashTogglesRst;
      cfg_q.alert_toggles    <= AlertTogglesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/bas_step.sv @@
// Next-state and result logic for one request of the battery alert sequencer.
// Depends on bas_pkg for cfg_t, item_t, seq_state_t, result_t and the codes.

module bas_step import bas_pkg::*; (
  input  cfg_t       cfg_i,
  input  item_t      item_i,
  input  seq_state_t state_i,
  output seq_state_t state_o,
  output result_t    result_o
);

  seq_state_t st;
  logic led_pulse, store_req, rt_pulse, shut_pulse;
  logic [CountW-1:0] tog_inc;

  assign tog_inc = state_i.toggle_count + CountW'(1);

  always_comb begin
    st         = state_i;
    led_pulse  = 1'b0;
    store_req  = 1'b0;
    rt_pulse   = 1'b0;
    shut_pulse = 1'b0;
    case (item_i.cmd)
      CMD_START: begin
        st.need_charge = item_i.need_charge_stored;
        st.phase       = PH_CHECK;
      end
      CMD_STOP: begin
        st.phase = PH_OFF;
      end
      CMD_TICK: begin
        if (state_i.elapsed_ms != ElapsedMax) begin
          st.elapsed_ms = state_i.elapsed_ms + MsW'(1);
        end
        if (item_i.level_valid) begin
          unique case (state_i.phase)
            PH_OFF: ;
            PH_CHECK: begin
              if (!state_i.need_charge && item_i.charge_pct > cfg_i.low_level) begin
                st.phase = PH_STARTUP;
              end else begin
                // Fresh low reading: raise the flag and ask for it to be saved.
                if (!state_i.need_charge) begin
                  st.need_charge = 1'b1;
                  store_req      = 1'b1;
                end
                led_pulse = 1'b1;
                st.phase  = PH_PON_ALERT;
              end
              st.elapsed_ms   = '0;
              st.toggle_count = '0;
            end
            PH_STARTUP: begin
              if (st.elapsed_ms > cfg_i.startup_delay_ms) begin
                st.phase        = PH_FLASH;
                st.elapsed_ms   = '0;
                st.toggle_count = '0;
              end
            end
            PH_FLASH: begin
              if (st.elapsed_ms > cfg_i.blink_period_ms) begin
                st.elapsed_ms   = '0;
                st.toggle_count = tog_inc;
                if (tog_inc >= cfg_i.flash_toggles) begin
                  st.phase        = PH_RUNTIME;
                  st.toggle_count = '0;
                end
              end
            end
            PH_RUNTIME: begin
              if (item_i.charge_pct <= cfg_i.critical_level) begin
                st.need_charge  = 1'b1;
                store_req       = 1'b1;
                rt_pulse        = 1'b1;
                st.phase        = PH_RT_ALERT;
                st.elapsed_ms   = '0;
                st.toggle_count = '0;
              end
            end
            PH_PON_ALERT, PH_RT_ALERT: begin
              if (st.elapsed_ms > cfg_i.blink_period_ms) begin
                st.elapsed_ms   = '0;
                st.toggle_count = tog_inc;
                // Toggle count is kept on shutdown; buzzer follows the phase.
                if (tog_inc >= cfg_i.alert_toggles) begin
                  shut_pulse = 1'b1;
                  st.phase   = PH_OFF;
                end
              end
            end
            default: st.phase = PH_OFF;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign state_o = st;

  assign result_o.phase               = phase_code(st.phase);
  assign result_o.buzzer_on           = ((st.phase == PH_PON_ALERT) ||
                                         (st.phase == PH_RT_ALERT)) && st.toggle_count[0];
  assign result_o.led_power_pulse     = led_pulse;
  assign result_o.store_request       = store_req;
  assign result_o.need_charge         = st.need_charge;
  assign result_o.runtime_alert_pulse = rt_pulse;
  assign result_o.shutdown_pulse      = shut_pulse;
  assign result_o.power_on_done       = (st.phase == PH_RUNTIME);

endmodule

@@ sv/battery_alert_sequencer_unit.sv @@
// Top level of the battery alert sequencer: request register, sequencer state,
// result register. Depends on bas_pkg, bas_cfg_regs and bas_step.

// Every request (a millisecond tick, a start or a stop) produces exactly one
// result. The block sustains one request per clock cycle while the output side
// is not stalled: a request is held in the input register, is evaluated
// combinationally against the sequencer state by bas_step, and is written into
// the result register once the output side is free, where its result shows on
// the outputs. The limit on rate is that single state update per cycle.
// in_ready_o stays high while the input register is empty or the result
// register is empty or being drained, so both registers fill before the input
// side stalls. Configuration writes are always taken (cfg_ready_o is tied
// high) and must only be issued while no request is in flight. There is no
// clearing pass after reset.

module battery_alert_sequencer_unit import bas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MsW-1:0]     cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [LevelW-1:0]  charge_pct_i,
  input  logic               level_valid_i,
  input  logic               need_charge_stored_i,
  // result channel
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [PhaseW-1:0]  phase_o,
  output logic               buzzer_on_o,
  output logic               led_power_pulse_o,
  output logic               store_request_o,
  output logic               need_charge_o,
  output logic               runtime_alert_pulse_o,
  output logic               shutdown_pulse_o,
  output logic               power_on_done_o
);

  cfg_t       cfg;
  item_t      item_q;
  logic       item_valid_q;
  seq_state_t state_q, state_d;
  result_t    res_d, res_q;
  logic       res_valid_q;
  logic       advance;
  logic       in_take;

  assign cfg_ready_o = 1'b1;

  bas_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held request into the result register when that slot frees up.
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  // Request payload: hold until evaluated.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd                <= cmd_i;
      item_q.charge_pct         <= charge_pct_i;
      item_q.level_valid        <= level_valid_i;
      item_q.need_charge_stored <= need_charge_stored_i;
    end
  end

  bas_step u_step (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state changes only when a request is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= PH_OFF;
      state_q.elapsed_ms   <= '0;
      state_q.toggle_count <= '0;
      state_q.need_charge  <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = res_valid_q;
  assign phase_o               = res_q.phase;
  assign buzzer_on_o           = res_q.buzzer_on;
  assign led_power_pulse_o     = res_q.led_power_pulse;
  assign store_request_o       = res_q.store_request;
  assign need_charge_o         = res_q.need_charge;
  assign runtime_alert_pulse_o = res_q.runtime_alert_pulse;
  assign shutdown_pulse_o      = res_q.shutdown_pulse;
  assign power_on_done_o       = res_q.power_on_done;

endmodule
